// ===== hw/rtl/bbsc_pkg.sv =====
package bbsc_pkg;

    localparam int MAX_POINTS = 2;
    localparam int PT_CNT_W   = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] CFG_SLOP      = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_BIAS      = 2'd2;

    localparam logic [15:0] SLOP_RESET      = 16'd2621;
    localparam logic [14:0] THRESHOLD_RESET = 15'd16056;
    localparam logic [16:0] BIAS_RESET      = 17'd52429;

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [15:0] a_cos;
        logic signed [15:0] a_sin;
        logic [30:0]        a_half_x;
        logic [30:0]        a_half_y;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [15:0] b_cos;
        logic signed [15:0] b_sin;
        logic [30:0]        b_half_x;
        logic [30:0]        b_half_y;
    } bbsc_in_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic [30:0]        depth;
        logic               ref_is_a;
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic               last;
    } bbsc_out_t;

    // Classified pair handed from the front part to the back part.
    typedef struct packed {
        logic               hit;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        depth;
        logic               refa;
        logic signed [31:0] cx0;
        logic signed [31:0] cx1;
        logic signed [31:0] cx2;
        logic signed [31:0] cx3;
        logic signed [31:0] cy0;
        logic signed [31:0] cy1;
        logic signed [31:0] cy2;
        logic signed [31:0] cy3;
        logic [3:0]         sel;
    } bbsc_job_t;

    function automatic logic signed [15:0] clamp_dir(input logic signed [15:0] v);
        if (v > 16'sd16384) begin
            return 16'sd16384;
        end
        if (v < -16'sd16384) begin
            return -16'sd16384;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/bbsc_front.sv =====
module bbsc_front import bbsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  bbsc_in_t    in_data,
    input  logic [15:0] slop,
    input  logic [14:0] threshold,
    input  logic [16:0] bias,
    output logic        job_valid,
    input  logic        job_ready,
    output bbsc_job_t   job
);

    // Stage 1: clamped directions, centre delta, axis cross dots.
    // Stage 2: projected radii, separation distance per axis.
    // Stage 3: overlaps, bias, axis choice, normal.
    // Stage 4: incident corners.
    // Stage 5: corner projections, selection mask.
    localparam int NST = 5;

    logic [NST-1:0] v_reg;
    logic           adv;

    assign adv      = !v_reg[NST-1] || job_ready;
    assign in_ready = adv;
    assign job_valid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // ---------------- stage 1 ----------------
    logic signed [15:0] ax1_reg [4];
    logic signed [15:0] ay1_reg [4];
    logic [30:0]        h1_reg  [4];
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [31:0] pax1_reg, pay1_reg, pbx1_reg, pby1_reg;
    logic [15:0]        c1_reg [4][4];

    logic signed [15:0] ca, sa, cb, sb;
    logic signed [15:0] axc [4];
    logic signed [15:0] ayc [4];

    always_comb begin
        ca = clamp_dir(in_data.a_cos);
        sa = clamp_dir(in_data.a_sin);
        cb = clamp_dir(in_data.b_cos);
        sb = clamp_dir(in_data.b_sin);
        axc[0] = ca;  ayc[0] = sa;
        axc[1] = -sa; ayc[1] = ca;
        axc[2] = cb;  ayc[2] = sb;
        axc[3] = -sb; ayc[3] = cb;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                ax1_reg[i] <= axc[i];
                ay1_reg[i] <= ayc[i];
                for (int k = 0; k < 4; k++) begin
                    logic signed [32:0] d;
                    logic [32:0]        m;
                    d = 33'(axc[k] * axc[i]) + 33'(ayc[k] * ayc[i]);
                    m = d[32] ? 33'(-d) : 33'(d);
                    c1_reg[i][k] <= 16'((m + 33'd8192) >> 14);
                end
            end
            h1_reg[0] <= in_data.a_half_x;
            h1_reg[1] <= in_data.a_half_y;
            h1_reg[2] <= in_data.b_half_x;
            h1_reg[3] <= in_data.b_half_y;
            dx1_reg   <= 33'(in_data.b_pos_x) - 33'(in_data.a_pos_x);
            dy1_reg   <= 33'(in_data.b_pos_y) - 33'(in_data.a_pos_y);
            pax1_reg  <= in_data.a_pos_x;
            pay1_reg  <= in_data.a_pos_y;
            pbx1_reg  <= in_data.b_pos_x;
            pby1_reg  <= in_data.b_pos_y;
        end
    end

    // ---------------- stage 2 ----------------
    logic signed [15:0] ax2_reg [4];
    logic signed [15:0] ay2_reg [4];
    logic [30:0]        h2_reg  [4];
    logic signed [31:0] pax2_reg, pay2_reg, pbx2_reg, pby2_reg;
    logic signed [50:0] dist2_reg [4];
    logic signed [49:0] dot2_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                logic [48:0]        proj;
                logic signed [49:0] dd;
                logic [49:0]        md;
                proj = '0;
                for (int k = 0; k < 4; k++) begin
                    proj = proj + 49'(c1_reg[i][k] * h1_reg[k]);
                end
                dd = 50'(dx1_reg * ax1_reg[i]) + 50'(dy1_reg * ay1_reg[i]);
                md = dd[49] ? 50'(-dd) : 50'(dd);
                dist2_reg[i] <= $signed({1'b0, md}) - $signed({2'b0, proj});
                dot2_reg[i]  <= dd;
            end
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            h2_reg   <= h1_reg;
            pax2_reg <= pax1_reg;
            pay2_reg <= pay1_reg;
            pbx2_reg <= pbx1_reg;
            pby2_reg <= pby1_reg;
        end
    end

    // ---------------- stage 3 ----------------
    logic               hit3_reg, refa3_reg;
    logic signed [15:0] nx3_reg, ny3_reg;
    logic [30:0]        depth3_reg;
    logic signed [15:0] kx0_reg, kx1_reg, ky0_reg, ky1_reg;
    logic [30:0]        hx3_reg, hy3_reg;
    logic signed [31:0] ox3_reg, oy3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic        sep;
            logic [37:0] ov;
            logic [37:0] minov;
            logic [1:0]  best;
            logic [15:0] aay;
            sep   = 1'b0;
            minov = '0;
            best  = '0;
            for (int i = 0; i < 4; i++) begin
                logic signed [50:0] nd;
                logic [55:0]        bp;
                if (dist2_reg[i] > 0) begin
                    sep = 1'b1;
                end
                nd  = -dist2_reg[i] + 51'sd8192;
                ov  = 38'(nd[51-1:14]);
                aay = ay2_reg[i][15] ? 16'(-ay2_reg[i]) : 16'(ay2_reg[i]);
                if (aay > {1'b0, threshold}) begin
                    bp = 56'(ov * bias) + 56'd32768;
                    ov = bp[53:16];
                end
                if (i == 0 || ov < minov) begin
                    minov = ov;
                    best  = 2'(i);
                end
            end
            hit3_reg   <= !sep;
            depth3_reg <= (minov > 38'h7FFF_FFFF) ? 31'h7FFF_FFFF : minov[30:0];
            refa3_reg  <= !best[1];
            if (dot2_reg[best] < 0) begin
                nx3_reg <= -ax2_reg[best];
                ny3_reg <= -ay2_reg[best];
            end else begin
                nx3_reg <= ax2_reg[best];
                ny3_reg <= ay2_reg[best];
            end
            if (!best[1]) begin
                kx0_reg <= ax2_reg[2]; kx1_reg <= ax2_reg[3];
                ky0_reg <= ay2_reg[2]; ky1_reg <= ay2_reg[3];
                hx3_reg <= h2_reg[2];  hy3_reg <= h2_reg[3];
                ox3_reg <= pbx2_reg;   oy3_reg <= pby2_reg;
            end else begin
                kx0_reg <= ax2_reg[0]; kx1_reg <= ax2_reg[1];
                ky0_reg <= ay2_reg[0]; ky1_reg <= ay2_reg[1];
                hx3_reg <= h2_reg[0];  hy3_reg <= h2_reg[1];
                ox3_reg <= pax2_reg;   oy3_reg <= pay2_reg;
            end
        end
    end

    // ---------------- stage 4 ----------------
    logic               hit4_reg, refa4_reg;
    logic signed [15:0] nx4_reg, ny4_reg;
    logic [30:0]        depth4_reg;
    logic signed [31:0] cx4_reg [4];
    logic signed [31:0] cy4_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [47:0] pxx, pxy, pyx, pyy;
            pxx = 48'($signed({1'b0, hx3_reg}) * kx0_reg);
            pxy = 48'($signed({1'b0, hy3_reg}) * kx1_reg);
            pyx = 48'($signed({1'b0, hx3_reg}) * ky0_reg);
            pyy = 48'($signed({1'b0, hy3_reg}) * ky1_reg);
            for (int i = 0; i < 4; i++) begin
                logic signed [49:0] sx, sy;
                logic signed [49:0] rx, ry;
                sx = ((i == 0 || i == 3) ? 50'(pxx) : -50'(pxx))
                   + ((i < 2) ? 50'(pxy) : -50'(pxy)) + 50'sd8192;
                sy = ((i == 0 || i == 3) ? 50'(pyx) : -50'(pyx))
                   + ((i < 2) ? 50'(pyy) : -50'(pyy)) + 50'sd8192;
                rx = sx >>> 14;
                ry = sy >>> 14;
                cx4_reg[i] <= sat32(66'(rx) + 66'(ox3_reg));
                cy4_reg[i] <= sat32(66'(ry) + 66'(oy3_reg));
            end
            hit4_reg   <= hit3_reg;
            refa4_reg  <= refa3_reg;
            nx4_reg    <= nx3_reg;
            ny4_reg    <= ny3_reg;
            depth4_reg <= depth3_reg;
        end
    end

    // ---------------- stage 5 ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [15:0] sdx, sdy;
            logic signed [48:0] pr [4];
            logic signed [48:0] maxp;
            logic signed [48:0] lim;
            logic [3:0]         sel;
            sdx = refa4_reg ? -nx4_reg : nx4_reg;
            sdy = refa4_reg ? -ny4_reg : ny4_reg;
            for (int i = 0; i < 4; i++) begin
                pr[i] = 49'(cx4_reg[i] * sdx) + 49'(cy4_reg[i] * sdy);
            end
            maxp = pr[0];
            for (int i = 1; i < 4; i++) begin
                if (pr[i] > maxp) begin
                    maxp = pr[i];
                end
            end
            lim = maxp - $signed({3'b0, slop, 14'b0});
            for (int i = 0; i < 4; i++) begin
                sel[i] = !(pr[i] < lim);
            end
            job.hit   <= hit4_reg;
            job.nx    <= nx4_reg;
            job.ny    <= ny4_reg;
            job.depth <= depth4_reg;
            job.refa  <= refa4_reg;
            job.cx0   <= cx4_reg[0];
            job.cx1   <= cx4_reg[1];
            job.cx2   <= cx4_reg[2];
            job.cx3   <= cx4_reg[3];
            job.cy0   <= cy4_reg[0];
            job.cy1   <= cy4_reg[1];
            job.cy2   <= cy4_reg[2];
            job.cy3   <= cy4_reg[3];
            job.sel   <= sel;
        end
    end

endmodule

// ===== hw/rtl/bbsc_queue.sv =====
module bbsc_queue import bbsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  bbsc_job_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output bbsc_job_t rd_data
);

    bbsc_job_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      do_wr, do_rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_wr) begin
                wp_reg <= !wp_reg;
            end
            if (do_rd) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/bbsc_back.sv =====
module bbsc_back import bbsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      job_valid,
    output logic      job_ready,
    input  bbsc_job_t job,
    output logic      out_valid,
    input  logic      out_ready,
    output bbsc_out_t out_data
);

    // One contact per cycle while out_ready allows; done_reg marks corners already emitted for the head job.
    logic [3:0]          done_reg;
    logic [PT_CNT_W-1:0] n_reg;
    logic                ov_reg;
    bbsc_out_t           od_reg;

    logic [3:0]          rem;
    logic [1:0]          idx;
    logic                found;
    logic [3:0]          rest;
    logic                is_last;
    logic                can;
    logic signed [31:0]  cx, cy;
    logic signed [46:0]  rx, ry;
    logic signed [31:0]  offx, offy;
    bbsc_out_t           res;

    always_comb begin
        rem   = job.sel & ~done_reg;
        idx   = 2'd0;
        found = 1'b0;
        for (int i = 3; i >= 0; i--) begin
            if (rem[i]) begin
                idx   = 2'(i);
                found = 1'b1;
            end
        end
        rest    = rem & ~(4'b1 << idx);
        is_last = !job.hit || rest == 4'b0 || 32'(n_reg) + 1 >= MAX_POINTS || !found;
        can     = !ov_reg || out_ready;
        case (idx)
            2'd0: begin cx = job.cx0; cy = job.cy0; end
            2'd1: begin cx = job.cx1; cy = job.cy1; end
            2'd2: begin cx = job.cx2; cy = job.cy2; end
            default: begin cx = job.cx3; cy = job.cy3; end
        endcase
        rx   = (47'(job.nx * $signed({1'b0, job.depth})) + 47'sd8192) >>> 14;
        ry   = (47'(job.ny * $signed({1'b0, job.depth})) + 47'sd8192) >>> 14;
        offx = rx[31:0];
        offy = ry[31:0];
        res  = '0;
        res.last = is_last;
        if (job.hit) begin
            res.hit      = 1'b1;
            res.normal_x = job.nx;
            res.normal_y = job.ny;
            res.depth    = job.depth;
            res.ref_is_a = job.refa;
            if (job.refa) begin
                res.point_b_x = cx;
                res.point_b_y = cy;
                res.point_a_x = sat32(66'(cx) + 66'(offx));
                res.point_a_y = sat32(66'(cy) + 66'(offy));
            end else begin
                res.point_a_x = cx;
                res.point_a_y = cy;
                res.point_b_x = sat32(66'(cx) - 66'(offx));
                res.point_b_y = sat32(66'(cy) - 66'(offy));
            end
        end
    end

    assign job_ready = job_valid && can && is_last;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg   <= 1'b0;
            done_reg <= '0;
            n_reg    <= '0;
        end else if (can) begin
            ov_reg <= job_valid;
            if (job_valid) begin
                if (is_last) begin
                    done_reg <= '0;
                    n_reg    <= '0;
                end else begin
                    done_reg <= done_reg | (4'b1 << idx);
                    n_reg    <= n_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (can && job_valid) begin
            od_reg <= res;
        end
    end

endmodule

// ===== hw/rtl/box_box_sat_contact_core.sv =====
// An accepted request passes the front stages, the job queue and the back part's output register.
// Throughput: one request per cycle into the front pipeline unless it stalls; the back
// part emits one result per cycle unless m_ready stalls it, and takes one pair at a time.
// Reset: synchronous active-low aresetn clears all valid flags and queue pointers
// and loads the configuration registers with their default values.
module box_box_sat_contact_core import bbsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bbsc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output bbsc_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] slop_reg;
    logic [14:0] thr_reg;
    logic [16:0] bias_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slop_reg <= SLOP_RESET;
            thr_reg  <= THRESHOLD_RESET;
            bias_reg <= BIAS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SLOP:      slop_reg <= cfg_data[15:0];
                CFG_THRESHOLD: thr_reg  <= cfg_data[14:0];
                CFG_BIAS:      bias_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic      fj_valid, fj_ready, bj_valid, bj_ready;
    bbsc_job_t fj, bj;

    bbsc_front u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_data),
        .slop(slop_reg), .threshold(thr_reg), .bias(bias_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    bbsc_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    bbsc_back u_back (
        .aclk, .aresetn,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(m_data)
    );

endmodule

// ===== verif/box_box_sat_contact_checker.sv =====
`timescale 1ns / 100ps

module box_box_sat_contact_checker import bbsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  bbsc_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  bbsc_out_t   m_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          hits_seen,
    output int          contacts_seen
);

    bbsc_out_t contact_q[$];
    logic [15:0] slop;
    logic [14:0] vert_thr;
    logic [16:0] vert_bias;

    function automatic longint dir_clamp(input logic signed [15:0] v);
        longint x;
        x = v;
        if (x > 16384) x = 16384;
        if (x < -16384) x = -16384;
        return x;
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint shift_round(input longint x, input int k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Predicts the results for one box pair and queues them; a separated pair gives one miss result.
    task automatic predict_contacts(input bbsc_in_t p);
        longint h[4], ux[4], uy[4], cx[4], cy[4], pr[4];
        longint dx, dy, minov, dep, nx, ny, sdx, sdy, ox, oy, hx, hy, maxp;
        longint proj, gap, ov, sx, sy, offx, offy;
        int best, n, kk;
        bit refa;
        bbsc_out_t r;
        best = -1;
        n = 0;
        minov = 0;
        dx = longint'(p.b_pos_x) - longint'(p.a_pos_x);
        dy = longint'(p.b_pos_y) - longint'(p.a_pos_y);
        h[0] = p.a_half_x; h[1] = p.a_half_y; h[2] = p.b_half_x; h[3] = p.b_half_y;
        ux[0] = dir_clamp(p.a_cos);  uy[0] = dir_clamp(p.a_sin);
        ux[1] = -uy[0];              uy[1] = ux[0];
        ux[2] = dir_clamp(p.b_cos);  uy[2] = dir_clamp(p.b_sin);
        ux[3] = -uy[2];              uy[3] = ux[2];
        for (int i = 0; i < 4; i++) begin
            proj = 0;
            for (int k = 0; k < 4; k++)
                proj += ((mag(ux[k] * ux[i] + uy[k] * uy[i]) + 8192) >>> 14) * h[k];
            gap = mag(dx * ux[i] + dy * uy[i]) - proj;
            if (gap > 0) begin
                r = '0;
                r.last = 1'b1;
                contact_q.insert(contact_q.size(), r);
                return;
            end
            ov = (-gap + 8192) >>> 14;
            if (mag(uy[i]) > longint'(vert_thr))
                ov = (ov * longint'(vert_bias) + 32768) >>> 16;
            if (best < 0 || ov < minov) begin
                minov = ov;
                best = i;
            end
        end
        dep = minov > 64'sd2147483647 ? 64'sd2147483647 : minov;
        nx = ux[best];
        ny = uy[best];
        if (dx * nx + dy * ny < 0) begin
            nx = -nx;
            ny = -ny;
        end
        refa = best < 2;
        kk = refa ? 2 : 0;
        ox = refa ? longint'(p.b_pos_x) : longint'(p.a_pos_x);
        oy = refa ? longint'(p.b_pos_y) : longint'(p.a_pos_y);
        hx = h[kk];
        hy = h[kk + 1];
        sdx = refa ? -nx : nx;
        sdy = refa ? -ny : ny;
        for (int i = 0; i < 4; i++) begin
            sx = (i == 0 || i == 3) ? 1 : -1;
            sy = (i < 2) ? 1 : -1;
            cx[i] = clip32(ox + shift_round(sx * hx * ux[kk] + sy * hy * ux[kk + 1], 14));
            cy[i] = clip32(oy + shift_round(sx * hx * uy[kk] + sy * hy * uy[kk + 1], 14));
            pr[i] = cx[i] * sdx + cy[i] * sdy;
        end
        maxp = pr[0];
        for (int i = 1; i < 4; i++)
            if (pr[i] > maxp) maxp = pr[i];
        offx = shift_round(nx * dep, 14);
        offy = shift_round(ny * dep, 14);
        for (int i = 0; i < 4 && n < MAX_POINTS; i++) begin
            if (pr[i] < maxp - longint'(slop) * 16384) continue;
            r = '0;
            r.hit = 1'b1;
            r.normal_x = nx[15:0];
            r.normal_y = ny[15:0];
            r.depth = dep[30:0];
            r.ref_is_a = refa;
            if (refa) begin
                r.point_b_x = cx[i][31:0];
                r.point_b_y = cy[i][31:0];
                r.point_a_x = 32'(clip32(cx[i] + offx));
                r.point_a_y = 32'(clip32(cy[i] + offy));
            end else begin
                r.point_a_x = cx[i][31:0];
                r.point_a_y = cy[i][31:0];
                r.point_b_x = 32'(clip32(cx[i] - offx));
                r.point_b_y = 32'(clip32(cy[i] - offy));
            end
            contact_q.insert(contact_q.size(), r);
            n++;
        end
        contact_q[$].last = 1'b1;
    endtask

    task automatic compare_field(input string name, input longint exp, input longint act);
        if (exp != act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
        end
    endtask

    always @(posedge aclk) begin
        bbsc_out_t e;
        if (!aresetn) begin
            slop <= SLOP_RESET;
            vert_thr <= THRESHOLD_RESET;
            vert_bias <= BIAS_RESET;
            errors = 0;
            hits_seen <= 0;
            contacts_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLOP:      slop <= cfg_data[15:0];
                    CFG_THRESHOLD: vert_thr <= cfg_data[14:0];
                    CFG_BIAS:      vert_bias <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_contacts(s_data);
            if (m_valid && m_ready) begin
                contacts_seen <= contacts_seen + 1;
                if (m_data.hit) hits_seen <= hits_seen + 1;
                if (contact_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h", $time, m_data);
                end else begin
                    e = contact_q.pop_front();
                    compare_field("hit", e.hit, m_data.hit);
                    compare_field("normal_x", e.normal_x, m_data.normal_x);
                    compare_field("normal_y", e.normal_y, m_data.normal_y);
                    compare_field("depth", e.depth, m_data.depth);
                    compare_field("ref_is_a", e.ref_is_a, m_data.ref_is_a);
                    compare_field("point_a_x", e.point_a_x, m_data.point_a_x);
                    compare_field("point_a_y", e.point_a_y, m_data.point_a_y);
                    compare_field("point_b_x", e.point_b_x, m_data.point_b_x);
                    compare_field("point_b_y", e.point_b_y, m_data.point_b_y);
                    compare_field("last", e.last, m_data.last);
                end
            end
        end
        pending <= contact_q.size();
    end

endmodule

// ===== verif/box_box_sat_contact_core_tb.sv =====
`timescale 1ns / 100ps

module box_box_sat_contact_core_tb;
    import bbsc_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    bbsc_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    bbsc_out_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          hits_seen;
    int          contacts_seen;
    int          idle_cycles;
    int          pairs_sent;

    box_box_sat_contact_core uut (.*);

    box_box_sat_contact_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Random backpressure on the result side, with calm stretches.
    initial begin
        int wait_n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            repeat (wait_n) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Run stopped after %0d box pairs: nothing moved for %0d cycles.",
                     pairs_sent, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'(signed'($urandom_range(0, 32768)) - 16384);
            1: return 16'($urandom);
            2: return 16'sd16384;
            3: return -16'sd16384;
            default: return 16'((signed'($urandom_range(0, 4096)) - 2048) * 4);
        endcase
    endfunction

    function automatic logic [30:0] rand_half(input bit wide);
        if (wide || $urandom_range(0, 15) == 0) return 31'($urandom);
        return 31'($urandom_range(0, 32'h0008_0000));
    endfunction

    function automatic logic signed [31:0] rand_pos(input bit wide);
        if (wide || $urandom_range(0, 15) == 0) return $urandom;
        return 32'(signed'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    // Valid stays high after acceptance until the next request or an idle gap.
    task automatic send_pair(input bbsc_in_t p);
        repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        pairs_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic bbsc_in_t random_pair(input bit wide);
        bbsc_in_t p;
        p.a_pos_x = rand_pos(wide);  p.a_pos_y = rand_pos(wide);
        p.b_pos_x = rand_pos(wide);  p.b_pos_y = rand_pos(wide);
        p.a_cos = rand_dir();        p.a_sin = rand_dir();
        p.b_cos = rand_dir();        p.b_sin = rand_dir();
        p.a_half_x = rand_half(wide); p.a_half_y = rand_half(wide);
        p.b_half_x = rand_half(wide); p.b_half_y = rand_half(wide);
        return p;
    endfunction

    initial begin
        bbsc_in_t p;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SLOP;
        cfg_data = '0;
        pairs_sent = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: axis-aligned overlap, touching, separation, extremes.
        p = '0;
        p.a_cos = 16'sd16384; p.b_cos = 16'sd16384;
        p.a_half_x = 31'h10000; p.a_half_y = 31'h10000;
        p.b_half_x = 31'h10000; p.b_half_y = 31'h10000;
        p.b_pos_x = 32'h18000;
        send_pair(p);
        p.b_pos_x = 32'h20000;
        send_pair(p);
        p.b_pos_x = 32'h20001;
        send_pair(p);
        p.b_pos_x = 0; p.b_pos_y = -32'sh18000;
        send_pair(p);
        p.b_pos_y = 0;
        send_pair(p);
        p.a_cos = '0; p.a_sin = '0; p.b_cos = '0; p.b_sin = '0;
        send_pair(p);
        p.a_cos = 16'h7FFF; p.a_sin = 16'h8000; p.b_cos = -16'sd16384; p.b_sin = 16'sd16384;
        send_pair(p);
        p.a_half_x = 31'h7FFF_FFFF; p.a_half_y = 31'h7FFF_FFFF;
        p.b_half_x = 31'h7FFF_FFFF; p.b_half_y = 31'h7FFF_FFFF;
        p.a_pos_x = 32'h7FFF_FFFF; p.a_pos_y = 32'h8000_0000;
        p.b_pos_x = 32'h8000_0000; p.b_pos_y = 32'h7FFF_FFFF;
        send_pair(p);
        p.a_cos = 16'sd11585; p.a_sin = 16'sd11585; p.b_cos = 16'sd16384; p.b_sin = '0;
        p.a_pos_x = 0; p.a_pos_y = 0; p.b_pos_x = 32'h8000; p.b_pos_y = 32'h8000;
        p.a_half_x = 31'h10000; p.a_half_y = 31'h8000;
        p.b_half_x = 31'h10000; p.b_half_y = 31'h10000;
        send_pair(p);
        p.b_cos = 16'sd11585; p.b_sin = -16'sd11585;
        send_pair(p);
        drain();

        // Random sets across register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_reg(CFG_SLOP, 0);
                    write_reg(CFG_THRESHOLD, 0);
                    write_reg(CFG_BIAS, 0);
                end
                2: begin
                    write_reg(CFG_SLOP, 32'hFFFF);
                    write_reg(CFG_THRESHOLD, 16384);
                    write_reg(CFG_BIAS, 65536);
                end
                default: begin
                    write_reg(CFG_SLOP, $urandom_range(0, 65535));
                    write_reg(CFG_THRESHOLD, $urandom_range(0, 16384));
                    write_reg(CFG_BIAS, $urandom_range(0, 65536));
                end
            endcase
            for (int n = 0; n < 280; n++)
                send_pair(random_pair($urandom_range(0, 9) == 0));
            drain();
        end

        $display("Sent %0d box pairs; %0d results checked, %0d of them contacts.",
                 pairs_sent, contacts_seen, hits_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
